/* src/etuc_pkg.sv */
`timescale 1ns / 1ps

package etuc_pkg;

    localparam int EPOCH_W = 38;
    localparam longint unsigned MAX_SECONDS = 64'd253402300799;

    // seconds per day is 2^7 * 675
    localparam int DAY_SHIFT = 7;
    localparam int HI_W      = EPOCH_W - DAY_SHIFT;
    localparam int DAYS_W    = 22;
    localparam int SOD_W     = 17;
    localparam int REM_W     = SOD_W - DAY_SHIFT;
    localparam int MOD_W     = 11;
    localparam int WQ_W      = 20;
    localparam int DOE_W     = 18;
    localparam int ERA_W     = 5;
    localparam int YOE_W     = 9;
    localparam int YEAR_W    = 14;
    localparam int DOY_W     = 9;

    // pads the time-of-day path out to the depth of the calendar path
    localparam int TOD_DLY = 5;

    localparam int unsigned DIV675        = 675;
    localparam int unsigned DIV60         = 60;
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam int unsigned FIRST_WEEKDAY = 4;
    localparam int unsigned DAYS_TO_MARCH0 = 719468;
    localparam int unsigned DAYS_PER_ERA   = 146097;
    localparam int unsigned DAYS_PER_4Y    = 1460;
    localparam int unsigned DAYS_PER_100Y  = 36524;
    localparam int unsigned DAYS_PER_YEAR  = 365;
    localparam int unsigned YEARS_PER_ERA  = 400;
    localparam int unsigned BASE_YEAR      = 1900;

    // first day of each month in a year that starts on march 1
    localparam logic [DOY_W-1:0] MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };
    localparam logic [3:0] MP_JANUARY   = 4'd10;
    localparam logic [3:0] MONTH_MARCH  = 4'd2;
    localparam logic [DOY_W-1:0] DAYS_JAN_FEB = 9'd59;

    // reciprocal multipliers: q = (x * M) >> K, exact for x below 2^N
    localparam int D675_K  = 41;
    localparam int D675_PW = 63;
    localparam longint unsigned D675_M =
        ((64'd1 << D675_K) + 64'(DIV675) - 64'd1) / 64'(DIV675);

    localparam int D60_K  = 23;
    localparam int D60_PW = 35;
    localparam longint unsigned D60_M =
        ((64'd1 << D60_K) + 64'(DIV60) - 64'd1) / 64'(DIV60);

    localparam int D7_K  = 25;
    localparam int D7_PW = 45;
    localparam longint unsigned D7_M =
        ((64'd1 << D7_K) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK);

    localparam int DERA_K  = 40;
    localparam int DERA_PW = 45;
    localparam longint unsigned DERA_M =
        ((64'd1 << DERA_K) + 64'(DAYS_PER_ERA) - 64'd1) / 64'(DAYS_PER_ERA);

    localparam int D4Y_K  = 29;
    localparam int D4Y_PW = 37;
    localparam longint unsigned D4Y_M =
        ((64'd1 << D4Y_K) + 64'(DAYS_PER_4Y) - 64'd1) / 64'(DAYS_PER_4Y);

    localparam int D100Y_K  = 34;
    localparam int D100Y_PW = 37;
    localparam longint unsigned D100Y_M =
        ((64'd1 << D100Y_K) + 64'(DAYS_PER_100Y) - 64'd1) / 64'(DAYS_PER_100Y);

    localparam int DY_K  = 27;
    localparam int DY_PW = 37;
    localparam longint unsigned DY_M =
        ((64'd1 << DY_K) + 64'(DAYS_PER_YEAR) - 64'd1) / 64'(DAYS_PER_YEAR);

    typedef struct packed {
        logic valid;
        logic oor;
    } t_ctl;

    typedef struct packed {
        logic [5:0] second;
        logic [5:0] minute;
        logic [4:0] hour;
        logic [2:0] weekday;
    } t_tod;

    typedef struct packed {
        logic [12:0] year_since_1900;
        logic [8:0]  day_of_year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
    } t_date;

endpackage

/* src/etuc_split.sv */
`timescale 1ns / 1ps

module etuc_split import etuc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_adv,
    input  logic                 i_valid,
    input  logic [EPOCH_W-1:0]   i_epoch_seconds,
    output t_ctl                 o_ctl,
    output logic [DAYS_W-1:0]    o_days,
    output logic [SOD_W-1:0]     o_sod
);

    t_ctl                    r_ctl1, n_ctl1;
    logic [D675_PW-1:0]      r_p675, n_p675;
    logic [HI_W-1:0]         r_hi, w_hi;
    logic [DAY_SHIFT-1:0]    r_lo;

    t_ctl                    r_ctl2;
    logic [DAYS_W-1:0]       r_days, n_days;
    logic [SOD_W-1:0]        r_sod, n_sod;
    logic [HI_W-1:0]         w_rem;

    always_comb begin
        w_hi        = i_epoch_seconds[EPOCH_W-1:DAY_SHIFT];
        n_ctl1.valid = i_valid;
        n_ctl1.oor   = 64'(i_epoch_seconds) > MAX_SECONDS;
        n_p675      = D675_PW'(w_hi) * D675_PW'(D675_M);

        // day count, then seconds of day from the remainder of the upper bits
        n_days = r_p675[D675_K +: DAYS_W];
        w_rem  = r_hi - HI_W'(n_days) * HI_W'(DIV675);
        n_sod  = {w_rem[REM_W-1:0], r_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else if (i_adv) begin
            r_ctl1 <= n_ctl1;
            r_ctl2 <= r_ctl1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_p675 <= n_p675;
            r_hi   <= w_hi;
            r_lo   <= i_epoch_seconds[DAY_SHIFT-1:0];
            r_days <= n_days;
            r_sod  <= n_sod;
        end
    end

    assign o_ctl  = r_ctl2;
    assign o_days = r_days;
    assign o_sod  = r_sod;

endmodule

/* src/etuc_clock.sv */
`timescale 1ns / 1ps

module etuc_clock import etuc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_adv,
    input  t_ctl               i_ctl,
    input  logic [DAYS_W-1:0]  i_days,
    input  logic [SOD_W-1:0]   i_sod,
    output t_ctl               o_ctl,
    output t_tod               o_tod
);

    t_ctl                  r3_ctl;
    logic [D60_PW-1:0]     r3_p60, n3_p60;
    logic [SOD_W-1:0]      r3_sod;
    logic [D7_PW-1:0]      r3_p7, n3_p7;
    logic [DAYS_W-1:0]     r3_w, n3_w;

    t_ctl                  r4_ctl;
    logic [MOD_W-1:0]      r4_mod, n4_mod;
    logic [5:0]            r4_sec, n4_sec;
    logic [2:0]            r4_wd, n4_wd;
    logic [WQ_W-1:0]       w4_q7;

    t_ctl                  r5_ctl;
    logic [D60_PW-1:0]     r5_p60, n5_p60;
    logic [MOD_W-1:0]      r5_mod;
    logic [5:0]            r5_sec;
    logic [2:0]            r5_wd;

    t_ctl                  r6_ctl;
    t_tod                  r6_tod, n6_tod;

    t_ctl                  r_dly_ctl [TOD_DLY];
    t_tod                  r_dly_tod [TOD_DLY];

    always_comb begin
        n3_p60 = D60_PW'(i_sod) * D60_PW'(D60_M);
        n3_w   = i_days + DAYS_W'(FIRST_WEEKDAY);
        n3_p7  = D7_PW'(n3_w) * D7_PW'(D7_M);

        n4_mod = r3_p60[D60_K +: MOD_W];
        n4_sec = 6'(r3_sod - SOD_W'(n4_mod) * SOD_W'(DIV60));
        w4_q7  = r3_p7[D7_K +: WQ_W];
        n4_wd  = 3'(r3_w - DAYS_W'(w4_q7) * DAYS_W'(DAYS_PER_WEEK));

        n5_p60 = D60_PW'(r4_mod) * D60_PW'(D60_M);

        n6_tod.hour    = r5_p60[D60_K +: 5];
        n6_tod.minute  = 6'(r5_mod - MOD_W'(n6_tod.hour) * MOD_W'(DIV60));
        n6_tod.second  = r5_sec;
        n6_tod.weekday = r5_wd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_ctl <= '0;
            r4_ctl <= '0;
            r5_ctl <= '0;
            r6_ctl <= '0;
            for (int k = 0; k < TOD_DLY; k++) begin
                r_dly_ctl[k] <= '0;
            end
        end else if (i_adv) begin
            r3_ctl <= i_ctl;
            r4_ctl <= r3_ctl;
            r5_ctl <= r4_ctl;
            r6_ctl <= r5_ctl;
            r_dly_ctl[0] <= r6_ctl;
            for (int k = 1; k < TOD_DLY; k++) begin
                r_dly_ctl[k] <= r_dly_ctl[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_p60 <= n3_p60;
            r3_sod <= i_sod;
            r3_p7  <= n3_p7;
            r3_w   <= n3_w;
            r4_mod <= n4_mod;
            r4_sec <= n4_sec;
            r4_wd  <= n4_wd;
            r5_p60 <= n5_p60;
            r5_mod <= r4_mod;
            r5_sec <= r4_sec;
            r5_wd  <= r4_wd;
            r6_tod <= n6_tod;
            r_dly_tod[0] <= r6_tod;
            for (int k = 1; k < TOD_DLY; k++) begin
                r_dly_tod[k] <= r_dly_tod[k-1];
            end
        end
    end

    assign o_ctl = r_dly_ctl[TOD_DLY-1];
    assign o_tod = r_dly_tod[TOD_DLY-1];

endmodule

/* src/etuc_civil.sv */
`timescale 1ns / 1ps

module etuc_civil import etuc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic [DAYS_W-1:0]  i_days,
    output t_date              o_date
);

    logic [DAYS_W-1:0]    r3_z, n3_z;
    logic [DERA_PW-1:0]   r3_pera, n3_pera;

    logic [ERA_W-1:0]     r4_era, n4_era;
    logic [DOE_W-1:0]     r4_doe, n4_doe;

    logic [D4Y_PW-1:0]    r5_p4y, n5_p4y;
    logic [D100Y_PW-1:0]  r5_p100y, n5_p100y;
    logic                 r5_last, n5_last;
    logic [DOE_W-1:0]     r5_doe;
    logic [ERA_W-1:0]     r5_era;

    logic [DOE_W-1:0]     r6_n, n6_n;
    logic [DOE_W-1:0]     r6_doe;
    logic [ERA_W-1:0]     r6_era;

    logic [DY_PW-1:0]     r7_py, n7_py;
    logic [DOE_W-1:0]     r7_doe;
    logic [ERA_W-1:0]     r7_era;

    logic [YOE_W-1:0]     r8_yoe;
    logic [DOE_W-1:0]     r8_doe;
    logic [ERA_W-1:0]     r8_era;

    logic [1:0]           w9_cent;
    logic [DOE_W-1:0]     w9_sub;
    logic [DOY_W-1:0]     r9_doy, n9_doy;
    logic                 r9_leap, n9_leap;
    logic [YEAR_W-1:0]    r9_year, n9_year;

    logic [3:0]           r10_mp, n10_mp;
    logic [DOY_W-1:0]     r10_doy;
    logic                 r10_leap;
    logic [YEAR_W-1:0]    r10_year;

    logic                 w11_jan_feb;
    t_date                r11_date, n11_date;

    always_comb begin
        n3_z    = i_days + DAYS_W'(DAYS_TO_MARCH0);
        n3_pera = DERA_PW'(n3_z) * DERA_PW'(DERA_M);

        n4_era = r3_pera[DERA_K +: ERA_W];
        n4_doe = DOE_W'(r3_z - DAYS_W'(n4_era) * DAYS_W'(DAYS_PER_ERA));

        n5_p4y   = D4Y_PW'(r4_doe) * D4Y_PW'(D4Y_M);
        n5_p100y = D100Y_PW'(r4_doe) * D100Y_PW'(D100Y_M);
        n5_last  = r4_doe == DOE_W'(DAYS_PER_ERA - 1);

        // remove leap days so that a plain divide by 365 gives the year of era
        n6_n = r5_doe - DOE_W'(r5_p4y[D4Y_K +: 7]) + DOE_W'(r5_p100y[D100Y_K +: 3])
             - DOE_W'(r5_last);

        n7_py = DY_PW'(r6_n) * DY_PW'(DY_M);

        w9_cent = {1'b0, r8_yoe >= YOE_W'(100)} + {1'b0, r8_yoe >= YOE_W'(200)}
                + {1'b0, r8_yoe >= YOE_W'(300)};
        w9_sub  = DOE_W'(r8_yoe) * DOE_W'(DAYS_PER_YEAR) + DOE_W'(r8_yoe >> 2)
                - DOE_W'(w9_cent);
        n9_doy  = DOY_W'(r8_doe - w9_sub);
        // era start is a multiple of 400, so only the first year of a century is special
        n9_leap = (r8_yoe[1:0] == 2'b00)
               && ((r8_yoe != YOE_W'(w9_cent) * YOE_W'(100)) || (r8_yoe == '0));
        n9_year = YEAR_W'(r8_era) * YEAR_W'(YEARS_PER_ERA) + YEAR_W'(r8_yoe);

        n10_mp = '0;
        for (int k = 1; k < 12; k++) begin
            if (r9_doy >= MONTH_START[k]) begin
                n10_mp = n10_mp + 4'd1;
            end
        end

        w11_jan_feb = r10_mp >= MP_JANUARY;
        n11_date.day_of_month = 5'(r10_doy - MONTH_START[r10_mp] + 9'd1);
        n11_date.month = w11_jan_feb ? r10_mp - MP_JANUARY : r10_mp + MONTH_MARCH;
        n11_date.year_since_1900 = 13'(r10_year + YEAR_W'(w11_jan_feb)
                                       - YEAR_W'(BASE_YEAR));
        n11_date.day_of_year = w11_jan_feb ? r10_doy - MONTH_START[MP_JANUARY]
                                           : r10_doy + DAYS_JAN_FEB + DOY_W'(r10_leap);
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r3_z     <= n3_z;
            r3_pera  <= n3_pera;
            r4_era   <= n4_era;
            r4_doe   <= n4_doe;
            r5_p4y   <= n5_p4y;
            r5_p100y <= n5_p100y;
            r5_last  <= n5_last;
            r5_doe   <= r4_doe;
            r5_era   <= r4_era;
            r6_n     <= n6_n;
            r6_doe   <= r5_doe;
            r6_era   <= r5_era;
            r7_py    <= n7_py;
            r7_doe   <= r6_doe;
            r7_era   <= r6_era;
            r8_yoe   <= r7_py[DY_K +: YOE_W];
            r8_doe   <= r7_doe;
            r8_era   <= r7_era;
            r9_doy   <= n9_doy;
            r9_leap  <= n9_leap;
            r9_year  <= n9_year;
            r10_mp   <= n10_mp;
            r10_doy  <= r9_doy;
            r10_leap <= r9_leap;
            r10_year <= r9_year;
            r11_date <= n11_date;
        end
    end

    assign o_date = r11_date;

endmodule

/* src/epoch_seconds_to_utc_calendar.sv */
`timescale 1ns / 1ps

// converts a count of seconds since 1970-01-01 00:00:00 utc to calendar fields
// input channel: i_in_valid / o_in_stall with i_epoch_seconds; a transfer happens
// on a rising edge with valid high and stall low
// output channel: o_out_valid / i_out_stall with one port per calendar field;
// o_out_of_range is set for inputs past 9999-12-31 23:59:59, and all other
// fields then read zero
// twelve register stages; one item can enter every cycle, so throughput is one
// item per cycle whenever the receiver does not stall; the depth is set by the
// chain of reciprocal multiplies on the day count (era, 4/100-year cycles, year
// of era) followed by the month search
// the pipeline holds as a whole while a result waits on a stalled receiver:
// o_in_stall is high exactly when the output register is full and stalled
// reset (synchronous, active low) clears all valid bits; items in flight are
// dropped and o_out_valid goes low

module epoch_seconds_to_utc_calendar import etuc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [EPOCH_W-1:0]  i_epoch_seconds,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [5:0]          o_second,
    output logic [5:0]          o_minute,
    output logic [4:0]          o_hour,
    output logic [2:0]          o_weekday,
    output logic [12:0]         o_year_since_1900,
    output logic [8:0]          o_day_of_year,
    output logic [3:0]          o_month,
    output logic [4:0]          o_day_of_month,
    output logic                o_out_of_range
);

    logic               w_adv;
    t_ctl               w_split_ctl;
    logic [DAYS_W-1:0]  w_days;
    logic [SOD_W-1:0]   w_sod;
    t_ctl               w_ctl;
    t_tod               w_tod;
    t_date              w_date;

    logic               r_out_valid;
    t_tod               r_tod;
    t_date              r_date;
    logic               r_oor;

    // everything moves unless a finished result is held by the receiver
    assign w_adv      = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_adv;

    etuc_split u_split (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_adv           (w_adv),
        .i_valid         (i_in_valid),
        .i_epoch_seconds (i_epoch_seconds),
        .o_ctl           (w_split_ctl),
        .o_days          (w_days),
        .o_sod           (w_sod)
    );

    etuc_clock u_clock (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_ctl   (w_split_ctl),
        .i_days  (w_days),
        .i_sod   (w_sod),
        .o_ctl   (w_ctl),
        .o_tod   (w_tod)
    );

    etuc_civil u_civil (
        .i_clk  (i_clk),
        .i_adv  (w_adv),
        .i_days (w_days),
        .o_date (w_date)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_oor <= w_ctl.oor;
            if (w_ctl.oor) begin
                r_tod  <= '0;
                r_date <= '0;
            end else begin
                r_tod  <= w_tod;
                r_date <= w_date;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_second          = r_tod.second;
    assign o_minute          = r_tod.minute;
    assign o_hour            = r_tod.hour;
    assign o_weekday         = r_tod.weekday;
    assign o_year_since_1900 = r_date.year_since_1900;
    assign o_day_of_year     = r_date.day_of_year;
    assign o_month           = r_date.month;
    assign o_day_of_month    = r_date.day_of_month;
    assign o_out_of_range    = r_oor;

endmodule

/* tb/tb_epoch_seconds_to_utc_calendar.sv */
`timescale 1ns / 1ps

module tb_epoch_seconds_to_utc_calendar;
    import etuc_pkg::*;

    localparam longint unsigned SECS_PER_DAY_TB = 86400;
    localparam longint unsigned ERA_DAYS        = 146097;
    localparam int unsigned     ERA_YEARS       = 400;
    localparam int unsigned     UNIX_YEAR       = 1970;
    localparam int unsigned     YEAR_BIAS       = 1900;
    localparam int unsigned     THURSDAY        = 4;
    localparam int unsigned     FEBRUARY        = 1;
    localparam int unsigned     DECEMBER        = 11;
    localparam longint unsigned LAST_SECOND     = 64'd253402300799;
    localparam longint unsigned LAST_DAY        = LAST_SECOND / SECS_PER_DAY_TB;
    localparam int              RANDOM_ITEMS    = 1500;
    localparam int              HOLD_OFF_CYCLES = 80;
    localparam int              IDLE_PCT        = 27;
    localparam int              STALL_LIMIT     = 2000;
    localparam int              TAIL_CYCLES     = 16;

    typedef struct packed {
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [2:0]  weekday;
        logic [12:0] year_since_1900;
        logic [8:0]  day_of_year;
        logic [3:0]  month;
        logic [4:0]  day_of_month;
        logic        out_of_range;
    } t_calendar;

    class calendar_scoreboard;
        t_calendar expected_q[$];
        int        mismatches = 0;
        int        conversions = 0;
        int        beyond_9999 = 0;
        int        leap_days = 0;

        function bit is_leap_year(int unsigned yr);
            return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        endfunction

        function int unsigned month_length(int unsigned mon, int unsigned yr);
            case (mon)
                FEBRUARY:     return is_leap_year(yr) ? 29 : 28;
                3, 5, 8, 10:  return 30;
                default:      return 31;
            endcase
        endfunction

        function t_calendar utc_fields_of(logic [EPOCH_W-1:0] secs);
            longint unsigned t;
            longint unsigned days;
            int unsigned     yr;
            int unsigned     mon;
            t_calendar       c;
            c = '0;
            if (64'(secs) > LAST_SECOND) begin
                c.out_of_range = 1'b1;
                return c;
            end
            t = 64'(secs);
            c.second = 6'(t % 60);
            t = t / 60;
            c.minute = 6'(t % 60);
            t = t / 60;
            c.hour = 5'(t % 24);
            days = t / 24;
            c.weekday = 3'((days + THURSDAY) % 7);
            // whole 400-year eras first, then walk the remaining years
            yr = UNIX_YEAR + ERA_YEARS * 32'(days / ERA_DAYS);
            days = days % ERA_DAYS;
            while (days >= (is_leap_year(yr) ? 366 : 365)) begin
                days = days - (is_leap_year(yr) ? 366 : 365);
                yr++;
            end
            c.year_since_1900 = 13'(yr - YEAR_BIAS);
            c.day_of_year = 9'(days);
            mon = 0;
            while (mon < DECEMBER && days >= month_length(mon, yr)) begin
                days = days - month_length(mon, yr);
                mon++;
            end
            c.month = 4'(mon);
            c.day_of_month = 5'(days + 1);
            return c;
        endfunction

        function void note_input(logic [EPOCH_W-1:0] secs);
            t_calendar c;
            c = utc_fields_of(secs);
            conversions++;
            if (c.out_of_range)
                beyond_9999++;
            else if (c.month == FEBRUARY && c.day_of_month == 29)
                leap_days++;
            expected_q.push_back(c);
        endfunction

        task report(string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, msg);
        endtask

        task check_field(string name, logic [12:0] got, logic [12:0] want);
            if (got !== want)
                report($sformatf("%s got %0d expected %0d", name, got, want));
        endtask

        task check_result(t_calendar got);
            t_calendar want;
            if (expected_q.size() == 0) begin
                report("result transfer with nothing outstanding");
                return;
            end
            want = expected_q.pop_front();
            check_field("second", 13'(got.second), 13'(want.second));
            check_field("minute", 13'(got.minute), 13'(want.minute));
            check_field("hour", 13'(got.hour), 13'(want.hour));
            check_field("weekday", 13'(got.weekday), 13'(want.weekday));
            check_field("year_since_1900", got.year_since_1900, want.year_since_1900);
            check_field("day_of_year", 13'(got.day_of_year), 13'(want.day_of_year));
            check_field("month", 13'(got.month), 13'(want.month));
            check_field("day_of_month", 13'(got.day_of_month), 13'(want.day_of_month));
            check_field("out_of_range", 13'(got.out_of_range), 13'(want.out_of_range));
        endtask
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [EPOCH_W-1:0] i_epoch_seconds = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [5:0]         o_second;
    logic [5:0]         o_minute;
    logic [4:0]         o_hour;
    logic [2:0]         o_weekday;
    logic [12:0]        o_year_since_1900;
    logic [8:0]         o_day_of_year;
    logic [3:0]         o_month;
    logic [4:0]         o_day_of_month;
    logic               o_out_of_range;

    calendar_scoreboard sb = new();

    logic steady = 1'b0;    // no idling on either side while set
    int   hold_req = 0;     // bumped by the sender side to ask for a long hold-off
    int   hold_ack = 0;
    int   hold_left = 0;

    epoch_seconds_to_utc_calendar uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_epoch_seconds  (i_epoch_seconds),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_second         (o_second),
        .o_minute         (o_minute),
        .o_hour           (o_hour),
        .o_weekday        (o_weekday),
        .o_year_since_1900(o_year_since_1900),
        .o_day_of_year    (o_day_of_year),
        .o_month          (o_month),
        .o_day_of_month   (o_day_of_month),
        .o_out_of_range   (o_out_of_range)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: check each transfer, then pick the stall for the next cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result(t_calendar'{o_second, o_minute, o_hour, o_weekday,
                                        o_year_since_1900, o_day_of_year, o_month,
                                        o_day_of_month, o_out_of_range});
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (hold_req != hold_ack) begin
            hold_ack = hold_req;
            hold_left = HOLD_OFF_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !steady && ($urandom_range(99, 0) < IDLE_PCT);
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("[%0t] no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("epoch_seconds_to_utc_calendar regression: fail");
        $finish;
    end

    task automatic send_epoch(input logic [EPOCH_W-1:0] secs);
        if (!steady && $urandom_range(99, 0) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99, 0) < IDLE_PCT);
        end
        i_in_valid <= 1'b1;
        i_epoch_seconds <= secs;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(secs);
    endtask

    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_q.size() != 0);
    endtask

    initial begin : stimulus
        logic [EPOCH_W-1:0] directed_times[$];
        logic [EPOCH_W-1:0] secs;
        logic [5:0]         top_bits;
        longint unsigned    r;
        longint unsigned    day;
        int unsigned        pick;

        directed_times = '{
            38'd0, 38'd1, 38'd59, 38'd60, 38'd3599, 38'd3600, 38'd86399, 38'd86400,
            38'd68169600,       // feb 29 1972
            38'd946684799,      // last second of 1999
            38'd951782400,      // feb 29 2000, century divisible by 400
            38'd951868800,      // mar 1 2000
            38'd978220800,      // dec 31 2000, day of year 365
            38'd4107456000,     // feb 28 2100, century not a leap year
            38'd4107542400,     // mar 1 2100
            38'h0_FFFF_FFFF, 38'h1_0000_0000, 38'h20_0000_0000,
            38'd253402300798, 38'd253402300799,
            38'd253402300800,   // first second past year 9999
            {EPOCH_W{1'b1}}
        };

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_times[k])
            send_epoch(directed_times[k]);

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300)
                hold_req <= hold_req + 1;
            if (n == 700)
                wait_for_drain();
            if (n == 900)
                steady <= 1'b1;
            if (n == 1150)
                steady <= 1'b0;
            top_bits = 6'($urandom_range(63, 0));
            r = {26'd0, top_bits, 32'($urandom())};
            pick = $urandom_range(99, 0);
            if (pick < 30) begin
                secs = r[EPOCH_W-1:0];
            end else if (pick < 70) begin
                secs = EPOCH_W'(r % (LAST_SECOND + 1));
            end else if (pick < 85) begin
                // land on or next to a midnight
                day = r % (LAST_DAY + 1);
                case ($urandom_range(3, 0))
                    0: secs = EPOCH_W'(day * SECS_PER_DAY_TB);
                    1: secs = EPOCH_W'(day * SECS_PER_DAY_TB + 1);
                    2: secs = EPOCH_W'(day * SECS_PER_DAY_TB + SECS_PER_DAY_TB - 2);
                    default: secs = EPOCH_W'(day * SECS_PER_DAY_TB + SECS_PER_DAY_TB - 1);
                endcase
            end else begin
                secs = EPOCH_W'(LAST_SECOND - 500 + $urandom_range(1000, 0));
            end
            send_epoch(secs);
        end

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d conversions: %0d past year 9999, %0d on feb 29",
                 sb.conversions, sb.beyond_9999, sb.leap_days);
        $display("random stalls on both sides, one long output hold-off, one full drain");
        if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
            $display("epoch_seconds_to_utc_calendar regression: pass");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.expected_q.size());
            $display("epoch_seconds_to_utc_calendar regression: fail");
        end
        $finish;
    end

endmodule
